// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the device identifier table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: rtl/dit_pkg.sv
// Constants and types of the device identifier table.
package dit_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int ID_W      = 64;
   localparam int CMD_W     = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int STATUS_W  = 2;
   localparam int COUNT_OUT_W = 7;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 16;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_SEARCH = 2'd0;
   localparam cmd_type CMD_CREATE = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

endpackage

// File: rtl/device_id_table.sv
// Top level of the device identifier table: command sequencer around one identifier RAM.
//
// Compacted table of active 64-bit device identifiers held in one RAM of TABLE_DEPTH words;
// the active entries always fill slots 0 to count-1 in order of creation. Each request
// transaction carries a command (search, create, delete) and an identifier, and yields
// exactly one response transaction with the slot, a status and the entry count after the
// operation. A create, an unused command, and a search or delete on an empty table go
// straight to the response state. A search walks the RAM one slot per cycle through its
// single read port until it hits or reaches the last entry. A delete that hits slot s
// scans the same way and then moves each later entry down one slot per cycle (read port
// and write port working together) before the response is offered.
// Only one command is in progress at a time; the next request is taken as soon as the
// sequencer is idle, even while the previous response still waits in the output register.
// The RAM needs no clearing after reset: only slots below the count are ever read.
module device_id_table #(
   parameter int TABLE_DEPTH = dit_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] command, [65:2] device_id, [71:66] zero
   input  logic [dit_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] slot_index, [7:6] status, [14:8] entry_count, [15] zero
   output logic [dit_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import dit_pkg::*;

`include "assert_macros.svh"

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = SLOT_W + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   // Sequencer state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   // Slot under compare during a scan, destination slot during a shift
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   status_type        res_status_ff, res_status_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ID_W-1:0]   key_ff, key_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [ID_W-1:0]   ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [ID_W-1:0]   ram_rd_data;

   cmd_type          req_cmd;
   logic [ID_W-1:0]  req_id;
   logic             req_accept;
   logic [CNT_W-1:0] walk_next_ext;
   logic [CNT_W-1:0] walk_next2_ext;
   logic             scan_hit;
   logic             scan_last;
   logic [SLOT_W+SLOT_OUT_W-1:0]  slot_ext;
   logic [CNT_W+COUNT_OUT_W-1:0]  count_ext;

   assign req_cmd    = req_tdata[CMD_W-1:0];
   assign req_id     = req_tdata[CMD_W+ID_W-1:CMD_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign walk_next_ext  = {1'b0, walk_ff} + CNT_W'(1);
   assign walk_next2_ext = {1'b0, walk_ff} + CNT_W'(2);
   assign scan_hit       = (ram_rd_data == key_ff);
   assign scan_last      = (walk_next_ext == count_ff);

   // Outputs carry the low bits of slot and count only
   assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot_ff};
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   dit_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE_DEPTH)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = walk_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = walk_next_ext[SLOT_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_cmd;
               key_in        = req_id;
               res_slot_in   = '0;
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
               priority if (req_cmd == CMD_SEARCH || req_cmd == CMD_DELETE) begin
                  if (count_ff != '0) begin
                     // Fetch slot 0, compare it next cycle
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     walk_in     = '0;
                     state_in    = S_SCAN;
                  end
               end else if (req_cmd == CMD_CREATE) begin
                  if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     // Append at the first free slot
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = count_ff[SLOT_W-1:0];
                     ram_wr_data   = req_id;
                     res_slot_in   = count_ff[SLOT_W-1:0];
                     res_status_in = ST_OK;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else begin
                  // Unused command: change nothing
                  res_status_in = ST_NOT_FOUND;
               end
            end
         end
         S_SCAN: begin
            priority if (scan_hit) begin
               res_slot_in   = walk_ff;
               res_status_in = ST_OK;
               if (cmd_ff == CMD_DELETE && !scan_last) begin
                  // Start moving the later entries down
                  ram_rd_en = 1'b1;
                  state_in  = S_SHIFT;
               end else begin
                  if (cmd_ff == CMD_DELETE) begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  state_in = S_RESP;
               end
            end else if (scan_last) begin
               res_slot_in   = '0;
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               ram_rd_en = 1'b1;
               walk_in   = walk_next_ext[SLOT_W-1:0];
            end
         end
         S_SHIFT: begin
            // Slot walk+1 arrives now: store it one slot lower
            ram_wr_en   = 1'b1;
            ram_wr_addr = walk_ff;
            ram_wr_data = ram_rd_data;
            if (walk_next2_ext < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = walk_next2_ext[SLOT_W-1:0];
               walk_in     = walk_next_ext[SLOT_W-1:0];
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, count_ext[COUNT_OUT_W-1:0], res_status_ff,
                               slot_ext[SLOT_OUT_W-1:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_CHECK(a_count_bounded, count_ff <= CNT_W'(TABLE_DEPTH), "entry count above depth")
   `ASSERT_CHECK(a_count_step, (count_ff != $past(count_ff)) |-> ((count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == $past(count_ff) - CNT_W'(1))), "entry count moved by more than one")
   `ASSERT_CHECK(a_write_source, ram_wr_en |-> ((state_ff == S_IDLE && req_accept) || state_ff == S_SHIFT), "RAM written outside create or shift")
   `ASSERT_CHECK(a_rsp_from_resp, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP), "response raised without a finished command")
   `ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "sequencer not idle after reset")

endmodule

// File: rtl/dit_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dit_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
